### hdl/efc_pkg.sv
`default_nettype none
package efc_pkg;

    localparam int DEFAULT_MAX_FRAME_BYTES = 2047;
    localparam int DEFAULT_QUEUE_DEPTH     = 2;

    localparam int MAC_W        = 48;
    localparam int IP_W         = 32;
    localparam int CFG_INDEX_W  = 2;
    localparam int OFFSET_W     = 7;
    localparam int OUT_LEN_W    = 11;
    localparam int OUT_TDATA_W  = 24;
    localparam int IN_TDATA_W   = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_STATION_MAC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_STATION_IP  = 2'd1;

    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETHERTYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_TCP      = 8'd6;

    localparam int MAC_BYTES    = 6;
    localparam int ETH_HDR_LEN  = 14;
    localparam int IPV4_MIN_HDR = 20;
    localparam int POS_ETYPE_HI = 12;
    localparam int POS_ETYPE_LO = 13;
    localparam int POS_IHL      = 14;
    localparam int POS_PROTO    = 23;
    localparam int POS_DIP_FIRST = 30;
    localparam int POS_DIP_LAST  = 33;

    typedef struct packed {
        logic        mac_equal;
        logic [15:0] ether_type;
        logic [3:0]  header_words;
        logic [7:0]  protocol;
        logic        dest_ip_equal;
    } efc_summary_t;

endpackage
`default_nettype wire

### hdl/efc_front.sv
`default_nettype none
module efc_front #(
    parameter int MAX_FRAME_BYTES = efc_pkg::DEFAULT_MAX_FRAME_BYTES,
    parameter int LEN_W           = $clog2(MAX_FRAME_BYTES + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [efc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [efc_pkg::MAC_W-1:0]     cfg_wdata,
    input  wire logic                          byte_valid,
    input  wire logic [7:0]                    frame_byte,
    input  wire logic                          last_byte,
    output logic                               rec_push,
    output logic [LEN_W-1:0]                   rec_len,
    output efc_pkg::efc_summary_t              rec_summary
);
    import efc_pkg::*;

    localparam efc_summary_t SUM_CLEAR = '{
        mac_equal:     1'b1,
        ether_type:    16'h0000,
        header_words:  4'h0,
        protocol:      8'h00,
        dest_ip_equal: 1'b1
    };

    logic [MAC_W-1:0] mac_reg;
    logic [IP_W-1:0]  ip_reg;

    logic [LEN_W-1:0] count_reg, count_next, count_upd;
    efc_summary_t     sum_reg, sum_next, sum_upd;
    logic [7:0]       mac_want, ip_want;

    always_comb begin
        unique case (count_reg[2:0])
            3'd0:    mac_want = mac_reg[47:40];
            3'd1:    mac_want = mac_reg[39:32];
            3'd2:    mac_want = mac_reg[31:24];
            3'd3:    mac_want = mac_reg[23:16];
            3'd4:    mac_want = mac_reg[15:8];
            3'd5:    mac_want = mac_reg[7:0];
            default: mac_want = 8'h00;
        endcase
        unique case (count_reg[1:0])
            2'b10:   ip_want = ip_reg[31:24];
            2'b11:   ip_want = ip_reg[23:16];
            2'b00:   ip_want = ip_reg[15:8];
            2'b01:   ip_want = ip_reg[7:0];
            default: ip_want = 8'h00;
        endcase
    end

    always_comb begin
        sum_upd   = sum_reg;
        count_upd = count_reg;
        if (count_reg < LEN_W'(MAC_BYTES)) begin
            if (frame_byte != mac_want) begin
                sum_upd.mac_equal = 1'b0;
            end
        end else if (count_reg == LEN_W'(POS_ETYPE_HI)) begin
            sum_upd.ether_type[15:8] = frame_byte;
        end else if (count_reg == LEN_W'(POS_ETYPE_LO)) begin
            sum_upd.ether_type[7:0] = frame_byte;
        end else if (count_reg == LEN_W'(POS_IHL)) begin
            sum_upd.header_words = frame_byte[3:0];
        end else if (count_reg == LEN_W'(POS_PROTO)) begin
            sum_upd.protocol = frame_byte;
        end else if (count_reg >= LEN_W'(POS_DIP_FIRST) &&
                     count_reg <= LEN_W'(POS_DIP_LAST)) begin
            if (frame_byte != ip_want) begin
                sum_upd.dest_ip_equal = 1'b0;
            end
        end
        if (count_reg < LEN_W'(MAX_FRAME_BYTES)) begin
            count_upd = count_reg + LEN_W'(1);
        end
    end

    always_comb begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (byte_valid) begin
            if (last_byte) begin
                count_next = '0;
                sum_next   = SUM_CLEAR;
            end else begin
                count_next = count_upd;
                sum_next   = sum_upd;
            end
        end
    end

    assign rec_push    = byte_valid && last_byte;
    assign rec_len     = count_upd;
    assign rec_summary = sum_upd;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mac_reg   <= '0;
            ip_reg    <= '0;
            count_reg <= '0;
            sum_reg   <= SUM_CLEAR;
        end else begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
            if (cfg_wr_en && cfg_index == REG_STATION_MAC) begin
                mac_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == REG_STATION_IP) begin
                ip_reg <= cfg_wdata[IP_W-1:0];
            end
        end
    end

endmodule
`default_nettype wire

### hdl/efc_queue.sv
`default_nettype none
module efc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = efc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_data
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] fill_reg;
    logic             do_push, do_pop;

    assign full      = (fill_reg == CNT_W'(DEPTH));
    assign not_empty = (fill_reg != '0);
    assign head_data = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - CNT_W'(1);
            end
        end
    end

endmodule
`default_nettype wire

### hdl/efc_back.sv
`default_nettype none
module efc_back #(
    parameter int LEN_W = 11
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         rec_valid,
    input  wire logic [LEN_W-1:0]             rec_len,
    input  wire efc_pkg::efc_summary_t        rec_summary,
    output logic                              rec_pop,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [efc_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import efc_pkg::*;

    logic                     valid_reg;
    logic                     link_hit, ipv4_hit, arp_hit, tcp_hit;
    logic [5:0]               hdr_bytes;
    logic [OFFSET_W-1:0]      offset;
    logic [LEN_W+OUT_LEN_W-1:0] len_ext;
    logic [OUT_TDATA_W-1:0]   data_reg, data_next;

    assign hdr_bytes = {rec_summary.header_words, 2'b00};
    assign len_ext   = {{OUT_LEN_W{1'b0}}, rec_len};

    always_comb begin
        link_hit = (rec_len >= LEN_W'(MAC_BYTES)) && rec_summary.mac_equal;
        arp_hit  = link_hit && (rec_summary.ether_type == ETHERTYPE_ARP) &&
                   (rec_len >= LEN_W'(ETH_HDR_LEN));
        ipv4_hit = link_hit && (rec_summary.ether_type == ETHERTYPE_IPV4) &&
                   (rec_len >= LEN_W'(ETH_HDR_LEN + IPV4_MIN_HDR)) &&
                   rec_summary.dest_ip_equal;
        tcp_hit  = ipv4_hit && (rec_summary.protocol == PROTO_TCP) &&
                   (len_ext >= (LEN_W + OUT_LEN_W)'(ETH_HDR_LEN) +
                               (LEN_W + OUT_LEN_W)'(hdr_bytes));
        offset   = tcp_hit ? OFFSET_W'(ETH_HDR_LEN) + OFFSET_W'(hdr_bytes) : '0;
        data_next = {2'b00, len_ext[OUT_LEN_W-1:0], offset,
                     tcp_hit, arp_hit, ipv4_hit, link_hit};
    end

    assign rec_pop  = rec_valid && (!valid_reg || m_tready);
    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

    always_ff @(posedge aclk) begin
        if (rec_pop) begin
            data_reg <= data_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (rec_pop) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

endmodule
`default_nettype wire

### hdl/ethernet_ipv4_frame_classifier.sv
// Channel   Direction  Ports                       Content
// s_        in         s_tvalid s_tready s_tdata   frame byte [7:0], last byte on s_tlast
// m_        out        m_tvalid m_tready m_tdata   one classification per frame
// cfg_      in         cfg_wr_en cfg_index cfg_wdata  station MAC (0), station IP (1)
//
// One byte transaction is taken every cycle while the queue is not full; the parser
// only updates a counter and flags. A result is queued, then held in the output register.
// Reset is synchronous and active low; it clears the frame state and both station registers.
// Results wait in a two-entry queue, so input stalls only when the queue is full.
`default_nettype none
module ethernet_ipv4_frame_classifier #(
    parameter int MAX_FRAME_BYTES = efc_pkg::DEFAULT_MAX_FRAME_BYTES,
    parameter int QUEUE_DEPTH     = efc_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [efc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [efc_pkg::MAC_W-1:0]         cfg_wdata,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [efc_pkg::IN_TDATA_W-1:0]    s_tdata,   // frame_byte [7:0]
    input  wire logic                              s_tlast,   // last_byte
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // link_hit [0], ipv4_hit [1], arp_hit [2], tcp_hit [3], transport_offset [10:4],
    // frame_length [21:11], zero [23:22]
    output logic [efc_pkg::OUT_TDATA_W-1:0]        m_tdata
);
    import efc_pkg::*;

    localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int REC_W = LEN_W + $bits(efc_summary_t);

    logic             q_full, q_valid, rec_push, rec_pop;
    logic [LEN_W-1:0] rec_len, head_len;
    efc_summary_t     rec_summary, head_summary;
    logic [REC_W-1:0] head_data;

    assign s_tready = !q_full;

    efc_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES),
        .LEN_W           (LEN_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .byte_valid  (s_tvalid && s_tready),
        .frame_byte  (s_tdata),
        .last_byte   (s_tlast),
        .rec_push    (rec_push),
        .rec_len     (rec_len),
        .rec_summary (rec_summary)
    );

    efc_queue #(
        .WIDTH (REC_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data ({rec_len, rec_summary}),
        .full      (q_full),
        .pop       (rec_pop),
        .not_empty (q_valid),
        .head_data (head_data)
    );

    assign head_len     = head_data[REC_W-1 -: LEN_W];
    assign head_summary = head_data[$bits(efc_summary_t)-1:0];

    efc_back #(
        .LEN_W (LEN_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .rec_valid   (q_valid),
        .rec_len     (head_len),
        .rec_summary (head_summary),
        .rec_pop     (rec_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
`default_nettype wire

### hdl/efc_checker.sv
`default_nettype none
module efc_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [efc_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import efc_pkg::*;

    // A stalled result transaction must stay offered.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result withdrawn while stalled");

    // A TCP hit implies an IPv4 hit, which implies a link hit and excludes ARP.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[3] |-> m_tdata[1] && m_tdata[0] && !m_tdata[2])
        else $error("inconsistent hit flags");

    // The transport offset lies between 14 and 74 on a TCP hit and is zero otherwise.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[3] ? (m_tdata[10:4] >= 7'(ETH_HDR_LEN) &&
                                    m_tdata[10:4] <= 7'd74)
                                 : (m_tdata[10:4] == 7'd0)))
        else $error("transport offset out of range");

    // No result may be offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered after reset");

endmodule

bind ethernet_ipv4_frame_classifier efc_checker u_efc_checker (.*);
`default_nettype wire

### verif/tb_ethernet_ipv4_frame_classifier.sv
`timescale 1ns / 100ps

module tb_ethernet_ipv4_frame_classifier;
    import efc_pkg::*;

    localparam int MAX_FRAME         = DEFAULT_MAX_FRAME_BYTES;
    localparam int SETTLE_CYCLES     = 16;
    localparam int HOLDOFF_CYCLES    = 200;
    localparam int PRESSURE_FRAMES   = 30;
    localparam int PRESSURE_AT_FRAME = 4;
    localparam int RANDOM_ITEMS      = 1000;
    localparam int RANDOM_FRAMES     = 20;
    localparam int DIRECTED_ROWS     = 21;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_3 = 2'd3;
    localparam logic [15:0]            VLAN_TPID   = 16'h8100;
    localparam logic [7:0]             PROTO_UDP   = 8'd17;

    typedef struct packed {
        logic [OUT_LEN_W-1:0] frame_length;
        logic [OFFSET_W-1:0]  transport_offset;
        logic                 tcp_hit;
        logic                 arp_hit;
        logic                 ipv4_hit;
        logic                 link_hit;
    } class_result_t;

    typedef enum logic {ROW_FRAME, ROW_CONFIG} row_kind_t;

    typedef struct packed {
        row_kind_t     kind;
        logic [11:0]   len;
        logic          mac_ok;
        logic [15:0]   etype;
        logic [7:0]    vihl;
        logic [7:0]    proto;
        logic          ip_ok;
        logic          known;
        class_result_t result;
        logic [47:0]   cfg_mac;
        logic [47:0]   cfg_ip;
    } directed_row_t;

    // Columns: kind, length, MAC match, ethertype, version/IHL, protocol, IP match,
    // expectation given, {length, offset, tcp, arp, ipv4, link}, MAC word, IP word.
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{ROW_FRAME, 1, 1, 16'h0000, 8'h00, 8'd0, 1, 1, '{1, 0, 0, 0, 0, 0}, 0, 0},
        '{ROW_FRAME, 5, 1, 16'h0000, 8'h00, 8'd0, 1, 1, '{5, 0, 0, 0, 0, 0}, 0, 0},
        '{ROW_FRAME, 6, 1, 16'h0000, 8'h00, 8'd0, 1, 1, '{6, 0, 0, 0, 0, 1}, 0, 0},
        '{ROW_CONFIG, 0, 0, 0, 0, 0, 0, 0, '0, 48'hFFFF_FFFF_FFFF, 48'h0000_FFFF_FFFF},
        '{ROW_FRAME, 14, 1, ETHERTYPE_ARP, 8'h45, 8'd0, 1, 1, '{14, 0, 0, 1, 0, 1}, 0, 0},
        '{ROW_FRAME, 13, 1, ETHERTYPE_ARP, 8'h45, 8'd0, 1, 1, '{13, 0, 0, 0, 0, 1}, 0, 0},
        '{ROW_FRAME, 60, 0, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 1, 1,
          '{60, 0, 0, 0, 0, 0}, 0, 0},
        '{ROW_FRAME, 34, 1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 1, 1,
          '{34, 34, 1, 0, 1, 1}, 0, 0},
        '{ROW_FRAME, 33, 1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 1, 1,
          '{33, 0, 0, 0, 0, 1}, 0, 0},
        '{ROW_FRAME, 74, 1, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 1, 1,
          '{74, 74, 1, 0, 1, 1}, 0, 0},
        '{ROW_FRAME, 73, 1, ETHERTYPE_IPV4, 8'h4F, PROTO_TCP, 1, 1,
          '{73, 0, 0, 0, 1, 1}, 0, 0},
        '{ROW_FRAME, 40, 1, ETHERTYPE_IPV4, 8'h40, PROTO_TCP, 1, 1,
          '{40, 14, 1, 0, 1, 1}, 0, 0},
        '{ROW_FRAME, 40, 1, ETHERTYPE_IPV4, 8'h45, PROTO_UDP, 1, 1,
          '{40, 0, 0, 0, 1, 1}, 0, 0},
        '{ROW_FRAME, 40, 1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 0, 1,
          '{40, 0, 0, 0, 0, 1}, 0, 0},
        '{ROW_FRAME, 40, 1, VLAN_TPID, 8'h45, PROTO_TCP, 1, 1, '{40, 0, 0, 0, 0, 1}, 0, 0},
        '{ROW_CONFIG, 0, 0, 0, 0, 0, 0, 0, '0, 48'h0200_5E10_2030, 48'hABCD_C0A8_0001},
        '{ROW_FRAME, 64, 1, ETHERTYPE_ARP, 8'hFF, 8'hFF, 1, 0, '0, 0, 0},
        '{ROW_FRAME, 50, 1, ETHERTYPE_IPV4, 8'h4A, PROTO_TCP, 1, 0, '0, 0, 0},
        '{ROW_FRAME, 1, 0, 16'h0000, 8'h00, 8'd0, 1, 0, '0, 0, 0},
        '{ROW_CONFIG, 0, 0, 0, 0, 0, 0, 0, '0, 48'h0000_0000_0000, 48'h0000_0000_0000},
        '{ROW_FRAME, 34, 1, ETHERTYPE_IPV4, 8'h45, PROTO_TCP, 1, 1,
          '{34, 34, 1, 0, 1, 1}, 0, 0}
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [MAC_W-1:0]       cfg_wdata = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata   = '0;
    logic                   s_tlast   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [MAC_W-1:0]     station_mac_q = '0;
    logic [IP_W-1:0]      station_ip_q  = '0;
    logic [OUT_LEN_W-1:0] rx_count      = '0;
    logic                 mac_seen_ok   = 1'b1;
    logic [15:0]          etype_seen    = '0;
    logic [3:0]           ihl_seen      = '0;
    logic [7:0]           proto_seen    = '0;
    logic                 dip_seen_ok   = 1'b1;

    class_result_t awaited_classes[$];
    class_result_t known_result;
    bit            known_override  = 1'b0;
    bit            tx_idling       = 1'b1;
    bit            rx_idling       = 1'b1;
    bit            holdoff_request = 1'b0;
    int            mismatches      = 0;

    ethernet_ipv4_frame_classifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic logic [47:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[47:0];
    endfunction

    function automatic bit classify_byte(input logic [7:0] b, input logic last,
                                         output class_result_t r);
        int pos;
        int hlen;
        pos = rx_count;
        r = '0;
        if (pos < MAC_BYTES) begin
            if (b != station_mac_q[8 * (MAC_BYTES - 1 - pos) +: 8]) mac_seen_ok = 1'b0;
        end else if (pos == POS_ETYPE_HI) begin
            etype_seen[15:8] = b;
        end else if (pos == POS_ETYPE_LO) begin
            etype_seen[7:0] = b;
        end else if (pos == POS_IHL) begin
            ihl_seen = b[3:0];
        end else if (pos == POS_PROTO) begin
            proto_seen = b;
        end else if (pos >= POS_DIP_FIRST && pos <= POS_DIP_LAST) begin
            if (b != station_ip_q[8 * (POS_DIP_LAST - pos) +: 8]) dip_seen_ok = 1'b0;
        end
        if (rx_count < MAX_FRAME) rx_count++;
        if (!last) return 1'b0;

        hlen = 4 * ihl_seen;
        r.frame_length = rx_count;
        r.link_hit = rx_count >= MAC_BYTES && mac_seen_ok;
        r.arp_hit  = r.link_hit && etype_seen == ETHERTYPE_ARP && rx_count >= ETH_HDR_LEN;
        r.ipv4_hit = r.link_hit && etype_seen == ETHERTYPE_IPV4 &&
                     rx_count >= ETH_HDR_LEN + IPV4_MIN_HDR && dip_seen_ok;
        r.tcp_hit  = r.ipv4_hit && proto_seen == PROTO_TCP &&
                     int'(rx_count) - ETH_HDR_LEN >= hlen;
        r.transport_offset = r.tcp_hit ? OFFSET_W'(ETH_HDR_LEN + hlen) : '0;

        rx_count    = '0;
        mac_seen_ok = 1'b1;
        etype_seen  = '0;
        ihl_seen    = '0;
        proto_seen  = '0;
        dip_seen_ok = 1'b1;
        return 1'b1;
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic last);
        class_result_t r;
        while (tx_idling && $urandom_range(99) < 20) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        if (classify_byte(b, last, r)) awaited_classes.push_back(known_override ? known_result : r);
    endtask

    task automatic send_frame(input int len, input bit mac_ok_f, input logic [15:0] etype,
                              input logic [7:0] vihl, input logic [7:0] proto,
                              input bit ip_ok_f);
        int mac_bad;
        int ip_bad;
        logic [7:0] b;
        mac_bad = mac_ok_f ? -1 : int'($urandom_range(MAC_BYTES - 1));
        ip_bad  = ip_ok_f ? -1 : int'($urandom_range(POS_DIP_LAST, POS_DIP_FIRST));
        for (int i = 0; i < len; i++) begin
            if (i < MAC_BYTES) b = station_mac_q[8 * (MAC_BYTES - 1 - i) +: 8];
            else if (i == POS_ETYPE_HI) b = etype[15:8];
            else if (i == POS_ETYPE_LO) b = etype[7:0];
            else if (i == POS_IHL) b = vihl;
            else if (i == POS_PROTO) b = proto;
            else if (i >= POS_DIP_FIRST && i <= POS_DIP_LAST)
                b = station_ip_q[8 * (POS_DIP_LAST - i) +: 8];
            else b = 8'($urandom);
            if (i == mac_bad || i == ip_bad) b = b ^ 8'($urandom_range(255, 1));
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (awaited_classes.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_config(input logic [47:0] mac_word, input logic [47:0] ip_word);
        cfg_wr_en <= 1'b1;
        cfg_index <= REG_STATION_MAC;
        cfg_wdata <= mac_word;
        @(posedge aclk);
        cfg_index <= REG_STATION_IP;
        cfg_wdata <= ip_word;
        @(posedge aclk);
        cfg_index <= $urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3;
        cfg_wdata <= rand48();
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        station_mac_q = mac_word;
        station_ip_q  = ip_word[IP_W-1:0];
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : check_results
        class_result_t got;
        class_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = class_result_t'(m_tdata[21:0]);
            if (awaited_classes.size() == 0) begin
                $error("classification transaction with none awaited: %h", m_tdata);
                mismatches++;
            end else begin
                want = awaited_classes.pop_front();
                check_field("link_hit", want.link_hit, got.link_hit);
                check_field("ipv4_hit", want.ipv4_hit, got.ipv4_hit);
                check_field("arp_hit", want.arp_hit, got.arp_hit);
                check_field("tcp_hit", want.tcp_hit, got.tcp_hit);
                check_field("transport_offset", want.transport_offset, got.transport_offset);
                check_field("frame_length", want.frame_length, got.frame_length);
                check_field("padding", 0, m_tdata[23:22]);
            end
        end
    end

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (holdoff_request) begin
                holdoff_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLDOFF_CYCLES) @(posedge aclk);
            end
            m_tready <= !(rx_idling && $urandom_range(99) < 20);
        end
    end

    initial begin : stimulus
        directed_row_t row;
        int frames;
        int bytes_sent;
        int len;
        int pick;
        logic [47:0] mac_word;
        logic [47:0] ip_word;
        logic [15:0] etype;
        logic [7:0]  vihl;
        logic [7:0]  proto;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            row = DIRECTED[i];
            if (row.kind == ROW_CONFIG) begin
                settle_block();
                apply_config(row.cfg_mac, row.cfg_ip);
            end else begin
                known_override = row.known;
                known_result   = row.result;
                send_frame(row.len, row.mac_ok, row.etype, row.vihl, row.proto, row.ip_ok);
            end
        end
        known_override = 1'b0;

        frames = 0;
        bytes_sent = 0;
        while (bytes_sent < RANDOM_ITEMS || frames < RANDOM_FRAMES) begin
            if (frames % 10 == 9) begin
                settle_block();
                mac_word = rand48();
                pick = $urandom_range(3);
                if (pick == 0) mac_word = '0;
                else if (pick == 1) mac_word = '1;
                ip_word = rand48();
                pick = $urandom_range(3);
                if (pick == 0) ip_word[IP_W-1:0] = '0;
                else if (pick == 1) ip_word[IP_W-1:0] = '1;
                apply_config(mac_word, ip_word);
            end

            tx_idling = !(frames >= 8 && frames < 16);
            rx_idling = tx_idling;

            if (frames == PRESSURE_AT_FRAME) begin
                holdoff_request = 1'b1;
                repeat (PRESSURE_FRAMES) send_byte(8'($urandom), 1'b1);
                bytes_sent += PRESSURE_FRAMES;
            end

            pick = $urandom_range(99);
            if (pick < 5) begin
                case ($urandom_range(5))
                    0: len = 13;
                    1: len = 14;
                    2: len = 33;
                    3: len = 34;
                    4: len = 73;
                    default: len = 74;
                endcase
            end else if (pick < 15) len = $urandom_range(13, 1);
            else if (pick < 30) len = $urandom_range(33, 14);
            else if (pick < 88) len = $urandom_range(80, 34);
            else len = $urandom_range(120, 81);

            pick = $urandom_range(99);
            if (pick < 50) etype = ETHERTYPE_IPV4;
            else if (pick < 65) etype = ETHERTYPE_ARP;
            else if (pick < 75) etype = VLAN_TPID;
            else etype = 16'($urandom);

            vihl = 8'($urandom);
            if ($urandom_range(1)) vihl[3:0] = 4'd5;
            proto = ($urandom_range(99) < 60) ? PROTO_TCP : 8'($urandom);

            send_frame(len, $urandom_range(99) < 85, etype, vihl, proto,
                       $urandom_range(99) < 85);
            frames++;
            bytes_sent += len;
        end

        settle_block();
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
